@@ src/packet_loss_jitter_monitor_macros.svh @@
// Assertion macros shared by the checker of the packet loss and jitter monitor.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef PACKET_LOSS_JITTER_MONITOR_MACROS_SVH
`define PACKET_LOSS_JITTER_MONITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLJ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/plj_pkg.sv @@
// Package of the packet loss and jitter monitor: field widths, payload types,
// controller states and the command and status groups. Depends on nothing.
`default_nettype none

package plj_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int SEQ_W             = 32;
	localparam int TIME_W            = 32;
	localparam int BYTES_W           = 64;
	localparam int JITTER_W          = 48;
	localparam int PB_W              = 16;
	localparam logic [PB_W-1:0] PB_RESET = 16'd1024;

	typedef struct packed {
		logic [SEQ_W-1:0]  sequence_number;
		logic [TIME_W-1:0] elapsed_ms;
	} pkt_t;

	typedef struct packed {
		logic [BYTES_W-1:0]         byte_total;
		logic [SEQ_W-1:0]           current_sequence;
		logic [SEQ_W-1:0]           lost_total;
		logic signed [JITTER_W-1:0] jitter_value;
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOSS,
		ST_COUNT,
		ST_DIV_A,
		ST_WAIT_A,
		ST_DIFF,
		ST_RESID,
		ST_DIV_B,
		ST_WAIT_B,
		ST_APPLY,
		ST_WRITE
	} plj_state_t;

	typedef struct packed {
		logic accept;
		logic upd_loss;
		logic set_count;
		logic div_start_a;
		logic take_x;
		logic take_resid;
		logic div_start_b;
		logic apply;
		logic write;
	} plj_cmd_t;

	typedef struct packed {
		logic stale;
		logic div_busy;
		logic out_free;
	} plj_stat_t;

endpackage

`default_nettype wire

@@ src/plj_stream_if.sv @@
// Valid/ready channel used for packets, status results and configuration writes.
// The payload type is a parameter; depends on nothing.
`default_nettype none

interface plj_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/plj_div.sv @@
// Iterative unsigned divider, two restoring quotient bits per cycle.
// Depends on plj_pkg for the divisor width.
`default_nettype none

module plj_div #(
	parameter int DW = 52
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [DW-1:0]            dividend,
	input  wire logic [plj_pkg::SEQ_W-1:0] divisor,
	output logic                          busy,
	output logic [DW-1:0]                 quotient
);
	import plj_pkg::*;

	localparam int STEPS = DW / 2;
	localparam int CW    = $clog2(STEPS + 1);

	logic [CW-1:0]    cnt_q;
	logic [SEQ_W-1:0] rem_q;
	logic [SEQ_W-1:0] den_q;
	logic [DW-1:0]    quo_q;
	logic [SEQ_W-1:0] rem_nx;
	logic [DW-1:0]    quo_nx;

	// Two dependent restoring steps; the remainder stays below the divisor.
	always_comb begin
		logic [SEQ_W:0] trial;
		logic           ge;
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int i = 0; i < 2; i++) begin
			trial  = {rem_nx, quo_nx[DW-1]};
			ge     = trial >= {1'b0, den_q};
			quo_nx = {quo_nx[DW-2:0], ge};
			rem_nx = ge ? SEQ_W'(trial - {1'b0, den_q}) : trial[SEQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ src/plj_datapath.sv @@
// Datapath of the packet loss and jitter monitor: session state, the jitter
// arithmetic, the shared divider and the result register. Depends on plj_pkg, plj_div.
`default_nettype none

module plj_datapath #(
	parameter int FRACTION_BITS = plj_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire plj_pkg::plj_cmd_t       cmd,
	output plj_pkg::plj_stat_t           stat,
	input  wire plj_pkg::pkt_t           in_data,
	input  wire logic                    cfg_valid,
	input  wire logic [plj_pkg::PB_W-1:0] cfg_data,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output plj_pkg::status_t             out_data
);
	import plj_pkg::*;

	localparam int XN = TIME_W + 2 + FRACTION_BITS;
	// Width of the residual x - j, which also bounds the arrival-time term.
	localparam int XW = (XN > JITTER_W ? XN : JITTER_W) + 1;
	localparam int DW = XW + (XW % 2);
	localparam int SW = XW + 1;
	localparam int AW = TIME_W + FRACTION_BITS;

	logic [PB_W-1:0]            pb_q;
	logic [SEQ_W-1:0]           last_q;
	logic [SEQ_W-1:0]           lost_q;
	logic [TIME_W-1:0]          prev_q;
	logic [BYTES_W-1:0]         bytes_q;
	logic signed [JITTER_W-1:0] jit_q;

	logic [SEQ_W-1:0]           seq_q;
	logic [TIME_W-1:0]          time_q;
	logic [SEQ_W-1:0]           n_q;
	logic signed [XW-1:0]       x_q;
	logic signed [XW-1:0]       r_q;
	logic signed [SW-1:0]       jsum_q;
	logic                       out_valid_q;
	status_t                    out_data_q;

	logic [SEQ_W-1:0]           count;
	logic signed [TIME_W:0]     diff;
	logic signed [XW-1:0]       diff_sh;
	logic signed [XW-1:0]       avg_ext;
	logic [XW-1:0]              r_mag;
	logic signed [SW-1:0]       j_ext;
	logic signed [SW-1:0]       q_ext;
	logic [SW-JITTER_W:0]       upper;
	logic signed [JITTER_W-1:0] jit_sat;
	logic                       div_start;
	logic [DW-1:0]              div_dividend;
	logic                       div_busy;
	logic [DW-1:0]              quot;

	assign div_start    = cmd.div_start_a | cmd.div_start_b;
	assign r_mag        = r_q[XW-1] ? XW'(-r_q) : XW'(r_q);
	assign div_dividend = cmd.div_start_b ? DW'(r_mag) : DW'({time_q, {FRACTION_BITS{1'b0}}});

	plj_div #(
		.DW(DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (n_q),
		.busy    (div_busy),
		.quotient(quot)
	);

	always_comb begin
		count   = seq_q - lost_q;
		diff    = $signed({1'b0, time_q}) - $signed({1'b0, prev_q});
		diff_sh = XW'(diff) <<< FRACTION_BITS;
		avg_ext = XW'(quot[AW-1:0]);
		j_ext   = SW'(jit_q);
		q_ext   = SW'(quot);
		upper   = jsum_q[SW-1:JITTER_W-1];
		if ((&upper) || !(|upper)) begin
			jit_sat = jsum_q[JITTER_W-1:0];
		end else if (jsum_q[SW-1]) begin
			jit_sat = {1'b1, {(JITTER_W-1){1'b0}}};
		end else begin
			jit_sat = {1'b0, {(JITTER_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pb_q <= PB_RESET;
		end else if (cfg_valid) begin
			pb_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			lost_q  <= '0;
			prev_q  <= '0;
			bytes_q <= '0;
			jit_q   <= '0;
		end else begin
			if (cmd.accept) begin
				bytes_q <= bytes_q + BYTES_W'(pb_q);
			end
			if (cmd.upd_loss) begin
				lost_q <= lost_q + seq_q - last_q - SEQ_W'(1);
				last_q <= seq_q;
			end
			if (cmd.write) begin
				jit_q  <= jit_sat;
				prev_q <= time_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			seq_q  <= in_data.sequence_number;
			time_q <= in_data.elapsed_ms;
		end
		if (cmd.set_count) begin
			n_q <= (count == '0) ? SEQ_W'(1) : count;
		end
		if (cmd.take_x) begin
			x_q <= diff_sh - avg_ext;
		end
		if (cmd.take_resid) begin
			r_q <= x_q - XW'(jit_q);
		end
		// Truncation toward zero: the magnitude quotient carries the residual's sign.
		if (cmd.apply) begin
			jsum_q <= r_q[XW-1] ? (j_ext - q_ext) : (j_ext + q_ext);
		end
		if (cmd.write) begin
			out_data_q.byte_total       <= bytes_q;
			out_data_q.current_sequence <= last_q;
			out_data_q.lost_total       <= lost_q;
			out_data_q.jitter_value     <= jit_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.stale    = in_data.sequence_number <= last_q;
	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

endmodule

`default_nettype wire

@@ src/plj_ctrl.sv @@
// Controller of the packet loss and jitter monitor: sequences one packet
// through the datapath. Depends on plj_pkg.
`default_nettype none

module plj_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire plj_pkg::plj_stat_t stat,
	output plj_pkg::plj_cmd_t      cmd
);
	import plj_pkg::*;

	plj_state_t state_q;
	plj_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					// A stale packet only adds to the byte total.
					if (!stat.stale) begin
						state_nx = ST_LOSS;
					end
				end
			end
			ST_LOSS: begin
				cmd.upd_loss = 1'b1;
				state_nx     = ST_COUNT;
			end
			ST_COUNT: begin
				cmd.set_count = 1'b1;
				state_nx      = ST_DIV_A;
			end
			ST_DIV_A: begin
				cmd.div_start_a = 1'b1;
				state_nx        = ST_WAIT_A;
			end
			ST_WAIT_A: begin
				if (!stat.div_busy) begin
					state_nx = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.take_x = 1'b1;
				state_nx   = ST_RESID;
			end
			ST_RESID: begin
				cmd.take_resid = 1'b1;
				state_nx       = ST_DIV_B;
			end
			ST_DIV_B: begin
				cmd.div_start_b = 1'b1;
				state_nx        = ST_WAIT_B;
			end
			ST_WAIT_B: begin
				if (!stat.div_busy) begin
					state_nx = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_nx  = ST_WRITE;
			end
			ST_WRITE: begin
				if (stat.out_free) begin
					cmd.write = 1'b1;
					state_nx  = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/packet_loss_jitter_monitor.sv @@
// Packet loss and jitter monitor: watches received packets (sequence number and
// arrival time in ms) and, for every packet whose sequence number is above the last
// one taken, returns the byte total, that sequence number, the lost count and the
// running jitter in signed fixed point with FRACTION_BITS fraction bits, saturating
// at 48 bits. Every packet, stale or not, adds the configured packet_bytes to the
// byte total; a stale or repeated packet returns nothing. An in-order packet makes
// two passes through one shared divider that retires two quotient bits per cycle.
// A new packet is taken as soon as the previous one is finished, while its result
// still waits in the output register. Configuration writes are always ready and
// should be made only while the block is idle. Depends on plj_pkg, plj_stream_if,
// plj_ctrl and plj_datapath.
`default_nettype none

module packet_loss_jitter_monitor #(
	parameter int FRACTION_BITS = plj_pkg::FRACTION_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	plj_stream_if.sink   pkt,
	plj_stream_if.source status,
	plj_stream_if.sink   cfg
);
	import plj_pkg::*;

	plj_cmd_t  cmd;
	plj_stat_t stat;

	plj_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pkt.valid),
		.in_ready(pkt.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	plj_datapath #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (pkt.data),
		.cfg_valid(cfg.valid),
		.cfg_data (cfg.data),
		.out_valid(status.valid),
		.out_ready(status.ready),
		.out_data (status.data)
	);

	assign cfg.ready = 1'b1;

endmodule

`default_nettype wire

@@ src/plj_checker.sv @@
// Port-level checker of the packet loss and jitter monitor and its bind statement.
// Depends on plj_pkg and packet_loss_jitter_monitor_macros.svh.
`default_nettype none
`include "packet_loss_jitter_monitor_macros.svh"

module plj_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             pkt_valid,
	input wire logic             pkt_ready,
	input wire logic             status_valid,
	input wire logic             status_ready,
	input wire plj_pkg::status_t status_data
);
	import plj_pkg::*;

	`PLJ_ASSERT_NEXT(a_status_held, clk, arst_n, status_valid && !status_ready, status_valid, "status result dropped while stalled")
	`PLJ_ASSERT_NEXT(a_status_stable, clk, arst_n, status_valid && !status_ready, $stable(status_data), "stalled status result changed")
	// A result is loaded as the controller returns to idle, so the input is open then.
	`PLJ_ASSERT_SAME(a_ready_on_result, clk, arst_n, $rose(status_valid), pkt_ready, "result appeared while input was closed")
	// A packet must pass through the controller's states, with both divider passes, before its result can appear.
	`PLJ_ASSERT_NEXT(a_no_instant_result, clk, arst_n, pkt_valid && pkt_ready, !$rose(status_valid), "result appeared right after a packet transaction")

endmodule

bind packet_loss_jitter_monitor plj_checker u_plj_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pkt_valid   (pkt.valid),
	.pkt_ready   (pkt.ready),
	.status_valid(status.valid),
	.status_ready(status.ready),
	.status_data (status.data)
);

`default_nettype wire
